>>> hdl/pfc_pkg.sv
//------------------------------------------------------------------------------
// pfc_pkg: shared definitions for the packet framer
// Holds the byte slot codes, the captured item record, the CRC constants
// and the byte-wise CRC-16/CCITT-FALSE update function.
//------------------------------------------------------------------------------
package pfc_pkg;

    // Configuration register indexes.
    localparam logic CFG_PAYLOAD_LENGTH = 1'b0;
    localparam logic CFG_PREAMBLE_WORD  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0]  LENGTH_RESET   = 8'd253;
    localparam logic [31:0] PREAMBLE_RESET = 32'hAAAA_AAAA;

    // CRC-16/CCITT-FALSE constants.
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Position of a byte within the framed stream.
    typedef enum logic [3:0] {
        SLOT_PRE0   = 4'd0,
        SLOT_PRE1   = 4'd1,
        SLOT_PRE2   = 4'd2,
        SLOT_PRE3   = 4'd3,
        SLOT_SEQ_LO = 4'd4,
        SLOT_SEQ_HI = 4'd5,
        SLOT_LENGTH = 4'd6,
        SLOT_DATA   = 4'd7,
        SLOT_CRC_LO = 4'd8,
        SLOT_CRC_HI = 4'd9
    } t_slot;

    // Everything needed to emit the bytes caused by one accepted item.
    typedef struct packed {
        logic        last;
        logic [31:0] preamble;
        logic [15:0] seq;
        logic [7:0]  length;
        logic [7:0]  data;
        logic [15:0] crc;
    } t_item;

    // One byte of CRC, MSB first, no reflection.
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/pfc_in_if.sv
//------------------------------------------------------------------------------
// pfc_in_if: payload byte channel
// Valid/ready channel carrying one payload byte per item.
//------------------------------------------------------------------------------
interface pfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;

    modport source (output valid, output payload_byte, input ready);
    modport sink   (input valid, input payload_byte, output ready);
endinterface

>>> hdl/pfc_out_if.sv
//------------------------------------------------------------------------------
// pfc_out_if: framed byte channel
// Valid/ready channel carrying one framed byte and its frame markers.
//------------------------------------------------------------------------------
interface pfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       first_of_frame;
    logic       last_of_frame;

    modport source (output valid, output frame_byte, output first_of_frame,
                    output last_of_frame, input ready);
    modport sink   (input valid, input frame_byte, input first_of_frame,
                    input last_of_frame, output ready);
endinterface

>>> hdl/packet_framer_crc16.sv
//------------------------------------------------------------------------------
// packet_framer_crc16: byte framer with CRC-16/CCITT-FALSE trailer
// Wraps payload bytes into frames: preamble, sequence number, length,
// payload and a two-byte CRC over the payload.
//
//   Channel   Dir   Payload                                     Handshake
//   i_in      in    payload_byte[7:0]                           valid/ready
//   o_out     out   frame_byte[7:0], first_of_frame, last_of_frame  valid/ready
//   cfg       in    i_cfg_index, i_cfg_data[31:0]               i_cfg_we
//
// One output byte leaves per cycle while the output is ready. Mid-frame payload
// bytes stream back to back; the first byte of a frame is preceded by the
// preamble, sequence and length bytes and the last is followed by the two CRC
// bytes, all emitted by the single byte sequencer. The CRC is updated at acceptance.
// Reset is synchronous and active low; it starts a new frame with sequence 0.
// A stalled output holds its byte while the next item waits in the item register.
//------------------------------------------------------------------------------
module packet_framer_crc16 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pfc_in_if.sink             i_in,
    pfc_out_if.source          o_out,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    // Configuration registers.
    logic [7:0]  r_length;
    logic [31:0] r_preamble;

    // Frame state.
    logic [15:0] r_seq;
    logic [7:0]  r_byte_index;
    logic [15:0] r_crc;

    // Item register and byte sequencer.
    pfc_pkg::t_item r_item;
    logic           r_item_valid;
    pfc_pkg::t_slot r_pos;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_first;
    logic       r_out_last;

    logic           in_ready;
    logic           in_acc;
    logic           out_load;
    logic           item_done;
    pfc_pkg::t_slot end_pos;
    logic [15:0]    n_crc;
    logic [8:0]     taken;
    logic           n_header;
    logic           n_last;
    logic [7:0]     n_byte;

    // Frame bookkeeping for the incoming item.
    always_comb begin
        n_header = (r_byte_index == 8'd0);
        n_crc    = pfc_pkg::crc_update(n_header ? pfc_pkg::CRC_INIT : r_crc,
                                       i_in.payload_byte);
        taken    = {1'b0, r_byte_index} + 9'd1;
        n_last   = (taken >= {1'b0, r_length});
    end

    // Handshake between the input, the sequencer and the output register.
    assign end_pos   = r_item.last ? pfc_pkg::SLOT_CRC_HI : pfc_pkg::SLOT_DATA;
    assign out_load  = r_item_valid && (!r_out_valid || o_out.ready);
    assign item_done = out_load && (r_pos == end_pos);
    assign in_ready  = !r_item_valid || item_done;
    assign in_acc    = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // Byte selected by the sequencer position.
    always_comb begin
        unique case (r_pos)
            pfc_pkg::SLOT_PRE0:   n_byte = r_item.preamble[31:24];
            pfc_pkg::SLOT_PRE1:   n_byte = r_item.preamble[23:16];
            pfc_pkg::SLOT_PRE2:   n_byte = r_item.preamble[15:8];
            pfc_pkg::SLOT_PRE3:   n_byte = r_item.preamble[7:0];
            pfc_pkg::SLOT_SEQ_LO: n_byte = r_item.seq[7:0];
            pfc_pkg::SLOT_SEQ_HI: n_byte = r_item.seq[15:8];
            pfc_pkg::SLOT_LENGTH: n_byte = r_item.length;
            pfc_pkg::SLOT_DATA:   n_byte = r_item.data;
            pfc_pkg::SLOT_CRC_LO: n_byte = r_item.crc[7:0];
            pfc_pkg::SLOT_CRC_HI: n_byte = r_item.crc[15:8];
            default:              n_byte = r_item.data;
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length   <= pfc_pkg::LENGTH_RESET;
            r_preamble <= pfc_pkg::PREAMBLE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pfc_pkg::CFG_PAYLOAD_LENGTH: r_length   <= i_cfg_data[7:0];
                pfc_pkg::CFG_PREAMBLE_WORD:  r_preamble <= i_cfg_data;
                default:                     r_length   <= r_length;
            endcase
        end
    end

    // Frame state advances when an item is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= 16'd0;
            r_byte_index <= 8'd0;
            r_crc        <= pfc_pkg::CRC_INIT;
        end else if (in_acc) begin
            if (n_last) begin
                r_seq        <= r_seq + 16'd1;
                r_byte_index <= 8'd0;
                r_crc        <= pfc_pkg::CRC_INIT;
            end else begin
                r_byte_index <= taken[7:0];
                r_crc        <= n_crc;
            end
        end
    end

    // Item capture; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.last     <= n_last;
            r_item.preamble <= r_preamble;
            r_item.seq      <= r_seq;
            r_item.length   <= r_length;
            r_item.data     <= i_in.payload_byte;
            r_item.crc      <= n_crc;
        end
    end

    // Sequencer: walks the slots of the held item, one byte per load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_pos        <= pfc_pkg::SLOT_PRE0;
        end else if (in_acc) begin
            r_item_valid <= 1'b1;
            r_pos        <= n_header ? pfc_pkg::SLOT_PRE0 : pfc_pkg::SLOT_DATA;
        end else if (item_done) begin
            r_item_valid <= 1'b0;
        end else if (out_load) begin
            r_pos <= pfc_pkg::t_slot'(r_pos + 4'd1);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte  <= n_byte;
            r_out_first <= (r_pos == pfc_pkg::SLOT_PRE0);
            r_out_last  <= (r_pos == pfc_pkg::SLOT_CRC_HI);
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.frame_byte     = r_out_byte;
    assign o_out.first_of_frame = r_out_first;
    assign o_out.last_of_frame  = r_out_last;

    // A loaded byte is offered on the next cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out.valid)
        else $error("loaded byte not offered");

    // A byte never both opens and closes a frame.
    a_first_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.first_of_frame && o_out.last_of_frame))
        else $error("byte marked as both first and last of frame");

    // Between frames the running CRC sits at its initial value.
    a_crc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_byte_index == 8'd0) |-> (r_crc == pfc_pkg::CRC_INIT))
        else $error("CRC not reinitialized at frame boundary");

    // An item only starts on a preamble byte or the payload slot.
    a_start_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_pos == pfc_pkg::SLOT_PRE0 || r_pos == pfc_pkg::SLOT_DATA))
        else $error("item started at a wrong slot");

endmodule
